// ===== sv/text_glyph_renderer_8x8_macros.svh =====
// ----------------------------------------------------------------------------
// text_glyph_renderer_8x8 assertion macros
// Short forms for the concurrent checks of the glyph renderer.
// ----------------------------------------------------------------------------
`ifndef TEXT_GLYPH_RENDERER_8X8_MACROS_SVH
`define TEXT_GLYPH_RENDERER_8X8_MACROS_SVH

// condition must hold at every edge outside reset
`define TGR_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TGR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/tgr_pkg.sv =====
// ----------------------------------------------------------------------------
// tgr_pkg
// Shared types, codes and constants of the 8x8 glyph renderer.
// ----------------------------------------------------------------------------
package tgr_pkg;

  // default sizes
  localparam int MAX_DIM_DEF     = 2048;
  localparam int GLYPH_COUNT_DEF = 256;
  localparam int GLYPH_SIZE      = 8;
  localparam int ROW_W           = $clog2(GLYPH_SIZE);
  localparam int CFG_ADDR_W      = 5;

  // register reset values
  localparam logic [11:0] WIDTH_RST  = 12'd640;
  localparam logic [11:0] HEIGHT_RST = 12'd480;
  localparam logic [31:0] FORE_RST   = 32'hFFFF_FFFF;
  localparam logic [31:0] BACK_RST   = 32'h0000_0000;
  localparam logic [31:0] MASK_RST   = 32'hFFFF_FFFF;

  // character codes
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DOT     = 8'h2E;

  // item commands
  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BEGIN = 2'd1,
    CMD_DRAW  = 2'd2
  } cmd_t;

  // register indexes
  typedef enum logic [2:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_FORE   = 3'd2,
    REG_BACK   = 3'd3,
    REG_MASK   = 3'd4
  } cfg_reg_t;

  // glyph draw request into the row engine
  typedef struct packed {
    logic        start;
    logic [7:0]  glyph;
    logic [21:0] base;
    logic [11:0] pitch;
  } draw_req_t;

  // glyph store write
  typedef struct packed {
    logic             wr;
    logic [7:0]       glyph;
    logic [ROW_W-1:0] row;
    logic [7:0]       bits;
  } glyph_wr_t;

  // colour configuration
  typedef struct packed {
    logic [31:0] fore;
    logic [31:0] back;
    logic [31:0] mask;
  } color_cfg_t;

  // colour of one pixel
  function automatic logic [31:0] pixel_color(input logic lit, input color_cfg_t c);
    return (lit ? c.fore : c.back) & c.mask;
  endfunction

endpackage

// ===== sv/tgr_in_if.sv =====
// ----------------------------------------------------------------------------
// tgr_in_if
// Item channel of the glyph renderer: valid/ready with the command payload.
// ----------------------------------------------------------------------------
interface tgr_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [7:0]        char_code;
  logic [2:0]        glyph_row;
  logic [7:0]        glyph_bits;
  logic signed [11:0] pos_x;
  logic signed [11:0] pos_y;

  modport source (
    output valid, command, char_code, glyph_row, glyph_bits, pos_x, pos_y,
    input  ready
  );

  modport sink (
    input  valid, command, char_code, glyph_row, glyph_bits, pos_x, pos_y,
    output ready
  );
endinterface

// ===== sv/tgr_out_if.sv =====
// ----------------------------------------------------------------------------
// tgr_out_if
// Row channel of the glyph renderer: valid/ready with address and pixels.
// ----------------------------------------------------------------------------
interface tgr_out_if;
  logic        valid;
  logic        ready;
  logic [21:0] row_address;
  logic [31:0] pixel_0;
  logic [31:0] pixel_1;
  logic [31:0] pixel_2;
  logic [31:0] pixel_3;
  logic [31:0] pixel_4;
  logic [31:0] pixel_5;
  logic [31:0] pixel_6;
  logic [31:0] pixel_7;
  logic        last_row;

  modport source (
    output valid, row_address, pixel_0, pixel_1, pixel_2, pixel_3,
           pixel_4, pixel_5, pixel_6, pixel_7, last_row,
    input  ready
  );

  modport sink (
    input  valid, row_address, pixel_0, pixel_1, pixel_2, pixel_3,
           pixel_4, pixel_5, pixel_6, pixel_7, last_row,
    output ready
  );
endinterface

// ===== sv/text_glyph_renderer_8x8.sv =====
// The first row of a drawn glyph passes the row sequencer, the read stage and
// the output register before it is valid. Throughput: one glyph row per cycle
// from the single read port of the glyph store while the row channel takes rows;
// a drawn character holds items back until its last row is read, other items do not.
// Reset: cursor, line origin and registers return to their reset values;
// the glyph store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// text_glyph_renderer_8x8
// Character stream to 8x8 glyph rows: cursor control, configuration port
// and the row engine that reads the glyph store.
// ----------------------------------------------------------------------------
`include "text_glyph_renderer_8x8_macros.svh"

module text_glyph_renderer_8x8 #(
  parameter int MAX_DIM     = tgr_pkg::MAX_DIM_DEF,
  parameter int GLYPH_COUNT = tgr_pkg::GLYPH_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  tgr_in_if.sink                        item,
  tgr_out_if.source                     row,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tgr_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import tgr_pkg::*;

  localparam int CW = ($clog2(2 * MAX_DIM) > 12) ? $clog2(2 * MAX_DIM) + 1 : 13;
  localparam int SW = CW + 1;
  localparam logic signed [SW-1:0] CUR_MAX = SW'(2 * MAX_DIM - 1);

  // configuration registers
  logic [11:0] width_q;
  logic [11:0] height_q;
  logic [31:0] fore_q;
  logic [31:0] back_q;
  logic [31:0] mask_q;
  cfg_reg_t    reg_sel;

  // cursor state
  logic signed [CW-1:0] origin_x, origin_x_next;
  logic signed [CW-1:0] cur_x, cur_x_next;
  logic signed [CW-1:0] cur_y, cur_y_next;

  logic                 acc;
  logic                 eng_ready;
  logic signed [CW-1:0] px, py;
  logic signed [SW-1:0] x_sum, y_sum;
  logic signed [CW-1:0] x_adv, y_adv;
  logic signed [SW-1:0] w_lim, h_lim;
  logic                 on_surface;
  logic [7:0]           code_eff;
  logic                 glyph_ok;
  logic                 is_newline;
  logic [23:0]          prod;
  draw_req_t            draw;
  glyph_wr_t            load;
  color_cfg_t           colors;

  // check terms
  logic                 cur_in_range;
  logic                 nl_acc;
  logic                 beg_acc;
  logic [3*CW-1:0]      cur_pos;
  logic [3*CW-1:0]      new_pos;

  // configuration port
  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      fore_q   <= FORE_RST;
      back_q   <= BACK_RST;
      mask_q   <= MASK_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_WIDTH:  width_q  <= pwdata[11:0];
        REG_HEIGHT: height_q <= pwdata[11:0];
        REG_FORE:   fore_q   <= pwdata;
        REG_BACK:   back_q   <= pwdata;
        REG_MASK:   mask_q   <= pwdata;
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_sel)
      REG_WIDTH:  prdata = {20'd0, width_q};
      REG_HEIGHT: prdata = {20'd0, height_q};
      REG_FORE:   prdata = fore_q;
      REG_BACK:   prdata = back_q;
      REG_MASK:   prdata = mask_q;
      default:    prdata = 32'd0;
    endcase
  end

  assign colors = '{fore: fore_q, back: back_q, mask: mask_q};

  // item transfer
  assign item.ready = eng_ready;
  assign acc        = item.valid && item.ready;

  // cursor arithmetic with saturation
  assign px    = $signed({{(CW-12){item.pos_x[11]}}, item.pos_x});
  assign py    = $signed({{(CW-12){item.pos_y[11]}}, item.pos_y});
  assign x_sum = $signed({cur_x[CW-1], cur_x}) + $signed(SW'(8));
  assign y_sum = $signed({cur_y[CW-1], cur_y}) + $signed(SW'(8));
  assign x_adv = (x_sum > CUR_MAX) ? CUR_MAX[CW-1:0] : x_sum[CW-1:0];
  assign y_adv = (y_sum > CUR_MAX) ? CUR_MAX[CW-1:0] : y_sum[CW-1:0];

  // surface bounds for a full 8x8 glyph
  assign w_lim = $signed({{(SW-12){1'b0}}, width_q}) - $signed(SW'(8));
  assign h_lim = $signed({{(SW-12){1'b0}}, height_q}) - $signed(SW'(8));
  assign on_surface = !cur_x[CW-1] && ($signed({cur_x[CW-1], cur_x}) <= w_lim) &&
                      !cur_y[CW-1] && ($signed({cur_y[CW-1], cur_y}) <= h_lim);

  // control codes other than newline, and high codes, draw a dot
  assign is_newline = (item.char_code == CH_NEWLINE);
  assign code_eff   = (item.char_code < CH_SPACE || item.char_code[7]) ? CH_DOT
                                                                        : item.char_code;
  assign glyph_ok   = ({1'b0, code_eff} < 9'(GLYPH_COUNT));

  // row start address of the glyph's top row
  assign prod = 24'(cur_y[11:0]) * 24'(width_q);

  // requests to the row engine
  always_comb begin
    draw.start = acc && (item.command == CMD_DRAW) && !is_newline && on_surface && glyph_ok;
    draw.glyph = code_eff;
    draw.base  = {10'd0, cur_x[11:0]} + prod[21:0];
    draw.pitch = width_q;
    load.wr    = acc && (item.command == CMD_LOAD) &&
                 ({1'b0, item.char_code} < 9'(GLYPH_COUNT));
    load.glyph = item.char_code;
    load.row   = item.glyph_row;
    load.bits  = item.glyph_bits;
  end

  // cursor next state
  always_comb begin
    origin_x_next = origin_x;
    cur_x_next    = cur_x;
    cur_y_next    = cur_y;
    if (acc) begin
      unique case (cmd_t'(item.command))
        CMD_BEGIN: begin
          origin_x_next = px;
          cur_x_next    = px;
          cur_y_next    = py;
        end
        CMD_DRAW: begin
          if (is_newline) begin
            cur_x_next = origin_x;
            cur_y_next = y_adv;
          end else begin
            cur_x_next = x_adv;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      cur_x    <= '0;
      cur_y    <= '0;
    end else begin
      origin_x <= origin_x_next;
      cur_x    <= cur_x_next;
      cur_y    <= cur_y_next;
    end
  end

  tgr_row_engine #(
    .GLYPH_COUNT(GLYPH_COUNT)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .draw   (draw),
    .load   (load),
    .colors (colors),
    .ready  (eng_ready),
    .row    (row)
  );

  // check terms, cursor compared as signed values
  assign cur_in_range = ($signed({cur_x[CW-1], cur_x}) <= CUR_MAX) &&
                        ($signed({cur_y[CW-1], cur_y}) <= CUR_MAX);
  assign nl_acc       = acc && (item.command == CMD_DRAW) && is_newline;
  assign beg_acc      = acc && (item.command == CMD_BEGIN);
  assign cur_pos      = {origin_x, cur_x, cur_y};
  assign new_pos      = {px, px, py};

  // checks
  `TGR_ASSERT_ALWAYS(a_cursor_sat, clk, rst, cur_in_range, "cursor above saturation limit")
  `TGR_ASSERT_NEXT(a_newline_x, clk, rst, nl_acc, cur_x == origin_x, "x not at line origin")
  `TGR_ASSERT_NEXT(a_begin_pos, clk, rst, beg_acc, cur_pos == $past(new_pos), "begin not applied")

endmodule

// ===== sv/tgr_row_engine.sv =====
// ----------------------------------------------------------------------------
// tgr_row_engine
// Glyph store memory and row sequencer: one glyph row read per cycle unless
// the row channel stalls, registered read data, then an output register to it.
// ----------------------------------------------------------------------------
module tgr_row_engine #(
  parameter int GLYPH_COUNT = tgr_pkg::GLYPH_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  tgr_pkg::draw_req_t  draw,
  input  tgr_pkg::glyph_wr_t  load,
  input  tgr_pkg::color_cfg_t colors,
  output logic                ready,
  tgr_out_if.source           row
);
  import tgr_pkg::*;

  localparam int DEPTH = GLYPH_COUNT * GLYPH_SIZE;
  localparam int IW    = $clog2(DEPTH);
  localparam int GW    = IW - ROW_W;
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GLYPH_SIZE - 1);

  // glyph store, contents undefined until loaded
  logic [7:0] glyph_mem [DEPTH];

  // sequencer
  logic             busy;
  logic [ROW_W-1:0] cnt;
  logic [GW-1:0]    glyph_q;
  logic [21:0]      addr_q;
  logic [11:0]      pitch_q;

  // read stage
  logic        s1_valid;
  logic [21:0] s1_addr;
  logic        s1_last;
  logic [7:0]  rd_bits;

  // output register
  logic        o_valid;
  logic [21:0] o_addr;
  logic        o_last;
  logic [7:0]  o_bits;

  logic o_adv;
  logic s1_free;
  logic issue;

  // stage movement
  assign o_adv   = !o_valid || row.ready;
  assign s1_free = !s1_valid || o_adv;
  assign issue   = busy && s1_free;
  assign ready   = !busy || (issue && cnt == LAST_ROW);

  // glyph store write port
  always_ff @(posedge clk) begin
    if (load.wr) begin
      glyph_mem[{load.glyph[GW-1:0], load.row}] <= load.bits;
    end
  end

  // glyph store read port, data held while the read stage stalls
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_bits <= glyph_mem[{glyph_q, cnt}];
    end
  end

  // row sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else begin
      if (draw.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (issue) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_ROW) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // sequencer payload: glyph, row address and pitch
  always_ff @(posedge clk) begin
    if (draw.start) begin
      glyph_q <= draw.glyph[GW-1:0];
      addr_q  <= draw.base;
      pitch_q <= draw.pitch;
    end else if (issue) begin
      addr_q <= addr_q + {10'd0, pitch_q};
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (issue) begin
      s1_valid <= 1'b1;
    end else if (o_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_addr <= addr_q;
      s1_last <= (cnt == LAST_ROW);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (o_adv) begin
      o_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_adv && s1_valid) begin
      o_addr <= s1_addr;
      o_last <= s1_last;
      o_bits <= rd_bits;
    end
  end

  // row channel, bit 7 is the leftmost pixel
  assign row.valid       = o_valid;
  assign row.row_address = o_addr;
  assign row.last_row    = o_last;
  assign row.pixel_0     = pixel_color(o_bits[7], colors);
  assign row.pixel_1     = pixel_color(o_bits[6], colors);
  assign row.pixel_2     = pixel_color(o_bits[5], colors);
  assign row.pixel_3     = pixel_color(o_bits[4], colors);
  assign row.pixel_4     = pixel_color(o_bits[3], colors);
  assign row.pixel_5     = pixel_color(o_bits[2], colors);
  assign row.pixel_6     = pixel_color(o_bits[1], colors);
  assign row.pixel_7     = pixel_color(o_bits[0], colors);

endmodule
